FILE: rtl/core/r2h_pkg.sv
package r2h_pkg;

   // quotient width shared by all three dividers (hue needs up to 300)
   localparam int unsigned QUO_BITS  = 9;
   localparam int unsigned HUE_STEP  = 60;
   localparam int unsigned HUE_GREEN = 120;
   localparam int unsigned HUE_BLUE  = 240;
   localparam int unsigned HUE_FULL  = 360;
   localparam int unsigned PCT_FULL  = 100;

   localparam int unsigned HUE_BITS = 9;
   localparam int unsigned PCT_BITS = 7;

   // per-pixel flags that ride alongside the divider pipeline
   typedef struct packed {
      logic azero;   // alpha was zero, nothing converted
      logic grey;    // all channels equal
      logic hneg;    // red sector with green below blue, hue wraps
   } side_type;

endpackage

FILE: rtl/core/r2h_if.sv
interface rgba_req_if #(
   parameter int CHANNEL_BITS = 8
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;
   logic [CHANNEL_BITS-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

interface hsv_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] hue;
   logic [6:0] saturation;
   logic [6:0] brightness;
   logic       written;
   logic       clipped;

   modport source (output valid, output hue, output saturation, output brightness,
                   output written, output clipped, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input written, input clipped, output ready);
endinterface

FILE: rtl/core/r2h_div.sv
module r2h_div
   import r2h_pkg::*;
#(
   parameter int NUM_BITS = 19,
   parameter int DEN_BITS = 9
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [QUO_BITS-1:0] quo,
   output logic                ovf
);

   localparam int WIDE_BITS = NUM_BITS + DEN_BITS + QUO_BITS;

   logic [NUM_BITS-1:0] rem_ff [0:QUO_BITS];
   logic [DEN_BITS-1:0] den_ff [0:QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [0:QUO_BITS];
   logic                ovf_ff [0:QUO_BITS];

   // entry stage: flag quotients that do not fit in QUO_BITS
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= WIDE_BITS'(num) >= (WIDE_BITS'(den) << QUO_BITS);
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar k = 1; k <= QUO_BITS; k++) begin : g_step
      logic [WIDE_BITS-1:0] trial_in;
      logic                 fits_in;

      assign trial_in = WIDE_BITS'(den_ff[k-1]) << (QUO_BITS - k);
      assign fits_in  = WIDE_BITS'(rem_ff[k-1]) >= trial_in;

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= fits_in ? NUM_BITS'(WIDE_BITS'(rem_ff[k-1]) - trial_in)
                                 : rem_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= {quo_ff[k-1][QUO_BITS-2:0], fits_in};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[QUO_BITS];
   assign ovf = ovf_ff[QUO_BITS];

endmodule

FILE: rtl/core/rgba_to_hsv_convert_core.sv
// Premultiplied RGBA to HSV conversion, fully pipelined.
// Throughput: one pixel per cycle; the stages advance whenever the output
// register is empty or being taken. Pipeline: 13 register stages (input register,
// operand stage, 10-stage restoring dividers, output); all stages hold under back-pressure.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
module rgba_to_hsv_convert_core
   import r2h_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   rgba_req_if.sink   req_ch,
   hsv_rsp_if.source  rsp_ch
);

   localparam int NW = CHANNEL_BITS + 11;
   localparam int DW = CHANNEL_BITS + 1;
   localparam int CB = CHANNEL_BITS;

   logic adv;

   // input register
   logic          s1_valid_ff;
   logic [CB-1:0] s1_r_ff, s1_g_ff, s1_b_ff, s1_a_ff;

   // operand register
   logic          s2_valid_ff;
   side_type      s2_side_ff;
   logic [NW-1:0] s2_hn_ff, s2_sn_ff, s2_vn_ff;
   logic [DW-1:0] s2_hd_ff, s2_sd_ff, s2_vd_ff;

   // flags that follow the divider stages
   logic     dv_valid_ff [0:QUO_BITS];
   side_type dv_side_ff  [0:QUO_BITS];

   logic                 out_valid_ff;
   logic [HUE_BITS-1:0]  out_hue_ff;
   logic [PCT_BITS-1:0]  out_sat_ff, out_val_ff;
   logic                 out_wr_ff, out_clip_ff;

   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // ---- operand stage logic ----
   logic [CB-1:0] mx_in, mn_in;
   logic [NW-1:0] d_in, hn_in;
   logic          hneg_in;
   side_type      side_in;

   always_comb begin
      mx_in = s1_r_ff;
      if (s1_g_ff > mx_in) mx_in = s1_g_ff;
      if (s1_b_ff > mx_in) mx_in = s1_b_ff;
      mn_in = s1_r_ff;
      if (s1_g_ff < mn_in) mn_in = s1_g_ff;
      if (s1_b_ff < mn_in) mn_in = s1_b_ff;
      d_in    = NW'(mx_in) - NW'(mn_in);
      hneg_in = 1'b0;
      if (mx_in == s1_r_ff) begin
         if (s1_g_ff >= s1_b_ff) begin
            hn_in = NW'(HUE_STEP) * (NW'(s1_g_ff) - NW'(s1_b_ff));
         end else begin
            hn_in   = NW'(HUE_STEP) * (NW'(s1_b_ff) - NW'(s1_g_ff));
            hneg_in = 1'b1;
         end
      end else if (mx_in == s1_g_ff) begin
         hn_in = NW'(HUE_STEP) * NW'(s1_b_ff) + NW'(HUE_GREEN) * d_in
               - NW'(HUE_STEP) * NW'(s1_r_ff);
      end else begin
         hn_in = NW'(HUE_STEP) * NW'(s1_r_ff) + NW'(HUE_BLUE) * d_in
               - NW'(HUE_STEP) * NW'(s1_g_ff);
      end
      side_in.azero = (s1_a_ff == '0);
      side_in.grey  = (d_in == '0);
      side_in.hneg  = hneg_in;
   end

   // ---- dividers: round(n/d) = floor((2n+d)/(2d)) ----
   logic [QUO_BITS-1:0] hq, sq, vq;
   logic                hovf, sovf, vovf;

   r2h_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_hue_div (
      .clock(clock), .enable(adv), .num(s2_hn_ff), .den(s2_hd_ff), .quo(hq), .ovf(hovf)
   );
   r2h_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_sat_div (
      .clock(clock), .enable(adv), .num(s2_sn_ff), .den(s2_sd_ff), .quo(sq), .ovf(sovf)
   );
   r2h_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_val_div (
      .clock(clock), .enable(adv), .num(s2_vn_ff), .den(s2_vd_ff), .quo(vq), .ovf(vovf)
   );

   // ---- final stage logic ----
   side_type            fs;
   logic [HUE_BITS-1:0] hue_in;
   logic [PCT_BITS-1:0] sat_in, val_in;
   logic                clip_in;

   always_comb begin
      fs      = dv_side_ff[QUO_BITS];
      clip_in = vovf || (vq > QUO_BITS'(PCT_FULL));
      val_in  = clip_in ? PCT_BITS'(PCT_FULL) : vq[PCT_BITS-1:0];
      if (fs.hneg) begin
         hue_in = (hq == '0) ? '0 : HUE_BITS'(HUE_FULL) - HUE_BITS'(hq);
      end else begin
         hue_in = HUE_BITS'(hq);
      end
      sat_in = sq[PCT_BITS-1:0];
      if (fs.grey) begin
         hue_in = '0;
         sat_in = '0;
      end
   end

   // ---- control (valid bits) ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i <= QUO_BITS; i++) dv_valid_ff[i] <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= req_ch.valid;
         s2_valid_ff    <= s1_valid_ff;
         dv_valid_ff[0] <= s2_valid_ff;
         for (int i = 1; i <= QUO_BITS; i++) dv_valid_ff[i] <= dv_valid_ff[i-1];
         out_valid_ff   <= dv_valid_ff[QUO_BITS];
      end
   end

   // ---- datapath ----
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_r_ff <= req_ch.red;
         s1_g_ff <= req_ch.green;
         s1_b_ff <= req_ch.blue;
         s1_a_ff <= req_ch.alpha;

         s2_side_ff <= side_in;
         s2_hn_ff   <= (hn_in << 1) + d_in;
         s2_hd_ff   <= DW'(d_in) << 1;
         s2_sn_ff   <= NW'(2 * PCT_FULL) * d_in + NW'(mx_in);
         s2_sd_ff   <= DW'(mx_in) << 1;
         s2_vn_ff   <= NW'(2 * PCT_FULL) * NW'(mx_in) + NW'(s1_a_ff);
         s2_vd_ff   <= DW'(s1_a_ff) << 1;

         dv_side_ff[0] <= s2_side_ff;
         for (int i = 1; i <= QUO_BITS; i++) dv_side_ff[i] <= dv_side_ff[i-1];

         if (fs.azero) begin
            out_hue_ff  <= '0;
            out_sat_ff  <= '0;
            out_val_ff  <= '0;
            out_wr_ff   <= 1'b0;
            out_clip_ff <= 1'b0;
         end else begin
            out_hue_ff  <= hue_in;
            out_sat_ff  <= sat_in;
            out_val_ff  <= val_in;
            out_wr_ff   <= 1'b1;
            out_clip_ff <= clip_in;
         end
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.hue        = out_hue_ff;
   assign rsp_ch.saturation = out_sat_ff;
   assign rsp_ch.brightness = out_val_ff;
   assign rsp_ch.written    = out_wr_ff;
   assign rsp_ch.clipped    = out_clip_ff;

   // ---- assertions ----
   a_quo_fits: assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[QUO_BITS] && !fs.azero && !fs.grey |-> !hovf && !sovf)
      else $error("hue or saturation quotient overflowed");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_hue_ff < HUE_BITS'(HUE_FULL) && out_sat_ff <= PCT_BITS'(PCT_FULL)
                       && out_val_ff <= PCT_BITS'(PCT_FULL))
      else $error("result field out of range");

   a_clip: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_clip_ff |-> out_val_ff == PCT_BITS'(PCT_FULL) && out_wr_ff)
      else $error("clipped result without full value");

   a_unwritten: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_wr_ff |-> out_hue_ff == '0 && out_sat_ff == '0
                                     && out_val_ff == '0 && !out_clip_ff)
      else $error("unwritten result carries data");

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 8;
   localparam int LATENCY = 12;

   typedef struct packed {
      logic [CB-1:0] red;
      logic [CB-1:0] green;
      logic [CB-1:0] blue;
      logic [CB-1:0] alpha;
   } pixel_t;

   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] brightness;
      logic       written;
      logic       clipped;
   } hsv_t;

   logic clock;
   logic reset;
   int   error_count;

   pixel_t pixel_queue[$];
   hsv_t   hsv_expected[$];

   rgba_req_if #(.CHANNEL_BITS(CB)) req_ch();
   hsv_rsp_if rsp_ch();

   rgba_to_hsv_convert_core #(.CHANNEL_BITS(CB)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // round(n/d), half away from zero, n >= 0
   function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
   endfunction

   function automatic hsv_t convert_hsv(pixel_t p);
      hsv_t o;
      longint unsigned r, g, b, a, mx, mn, d, h, v;
      o = '0;
      r = 64'(p.red); g = 64'(p.green); b = 64'(p.blue); a = 64'(p.alpha);
      if (a == 0) return o;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      d = mx - mn;
      v = div_round(100 * mx, a);
      o.written = 1'b1;
      if (v > 100) begin
         v = 100;
         o.clipped = 1'b1;
      end
      o.brightness = v[6:0];
      if (d != 0) begin
         if (mx == r) begin
            if (g >= b) h = div_round(60 * (g - b), d);
            else h = (360 - div_round(60 * (b - g), d)) % 360;
         end else if (mx == g) begin
            h = div_round(60 * b + 120 * d - 60 * r, d);
         end else begin
            h = div_round(60 * r + 240 * d - 60 * g, d);
         end
         h = h % 360;
         o.hue = h[8:0];
         o.saturation = 7'(div_round(100 * d, mx));
      end
      return o;
   endfunction

   task automatic report(string what, int got, int want);
      $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // driver
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) hsv_expected.push_back(convert_hsv({req_ch.red, req_ch.green,
                                                                 req_ch.blue, req_ch.alpha}));
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            pixel_t p;
            p = pixel_queue.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.red   <= p.red;
            req_ch.green <= p.green;
            req_ch.blue  <= p.blue;
            req_ch.alpha <= p.alpha;
            send_gap = gap_len();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor with random back-pressure
   int stall_len;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_len = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (hsv_expected.size() == 0) begin
               report("unexpected transaction", 0, 0);
            end else begin
               hsv_t w;
               w = hsv_expected.pop_front();
               if (rsp_ch.hue !== w.hue) report("hue", int'(rsp_ch.hue), int'(w.hue));
               if (rsp_ch.saturation !== w.saturation)
                  report("saturation", int'(rsp_ch.saturation), int'(w.saturation));
               if (rsp_ch.brightness !== w.brightness)
                  report("brightness", int'(rsp_ch.brightness), int'(w.brightness));
               if (rsp_ch.written !== w.written)
                  report("written", int'(rsp_ch.written), int'(w.written));
               if (rsp_ch.clipped !== w.clipped)
                  report("clipped", int'(rsp_ch.clipped), int'(w.clipped));
            end
         end
         if (stall_len > 0) begin
            stall_len--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_len = gap_len();
         end
      end
   end

   function automatic pixel_t mk(int r, int g, int b, int a);
      return {8'(r), 8'(g), 8'(b), 8'(a)};
   endfunction

   initial begin
      int k;
      pixel_t p;
      reset = 1'b1;
      error_count = 0;
      req_ch.valid = 1'b0;
      req_ch.red = '0; req_ch.green = '0; req_ch.blue = '0; req_ch.alpha = '0;
      rsp_ch.ready = 1'b0;
      // directed: alpha zero, grey, sector ties, clipping, extremes
      pixel_queue.push_back(mk(10, 20, 30, 0));
      pixel_queue.push_back(mk(255, 255, 255, 0));
      pixel_queue.push_back(mk(0, 0, 0, 255));
      pixel_queue.push_back(mk(255, 255, 255, 255));
      pixel_queue.push_back(mk(77, 77, 77, 200));
      pixel_queue.push_back(mk(255, 0, 0, 255));
      pixel_queue.push_back(mk(0, 255, 0, 255));
      pixel_queue.push_back(mk(0, 0, 255, 255));
      pixel_queue.push_back(mk(255, 255, 0, 255));
      pixel_queue.push_back(mk(0, 255, 255, 255));
      pixel_queue.push_back(mk(255, 0, 255, 255));
      pixel_queue.push_back(mk(255, 0, 1, 255));
      pixel_queue.push_back(mk(255, 1, 0, 255));
      pixel_queue.push_back(mk(1, 0, 255, 255));
      pixel_queue.push_back(mk(200, 100, 50, 1));
      pixel_queue.push_back(mk(255, 254, 0, 128));
      pixel_queue.push_back(mk(1, 0, 0, 1));
      pixel_queue.push_back(mk(3, 1, 2, 2));
      pixel_queue.push_back(mk(128, 127, 129, 255));
      pixel_queue.push_back(mk(170, 85, 0, 170));
      for (int i = 0; i < 1750; i++) begin
         k = $urandom_range(0, 9);
         p.alpha = (k == 0) ? 8'd0 : 8'($urandom_range(1, 255));
         if (k < 6 && p.alpha != 0) begin
            // well-formed premultiplied pixel
            p.red   = 8'($urandom_range(0, p.alpha));
            p.green = 8'($urandom_range(0, p.alpha));
            p.blue  = 8'($urandom_range(0, p.alpha));
         end else begin
            p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
         end
         if (k == 9) p.green = p.red;
         pixel_queue.push_back(p);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pixel_queue.size() == 0);
      @(posedge clock);
      while (req_ch.valid || hsv_expected.size() != 0) @(posedge clock);
      repeat (LATENCY * 4) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: done, errors");
      $finish;
   end
endmodule
